// ----- hw/rtl/sspwm_pkg.sv -----
// ----------------------------------------------------------------------------
// sspwm_pkg - shared definitions for the sequential slot PWM
// Operation codes, default sizes and the request and result records that
// travel between the handshake shell and the slot engine.
// ----------------------------------------------------------------------------
package sspwm_pkg;

  // Default channel count and tick counter width.
  localparam int NUM_CHANNELS_DEF = 8;
  localparam int COUNT_BITS_DEF   = 24;

  // Fixed field widths of the request and result channels.
  localparam int OP_W      = 2;
  localparam int CHANNEL_W = 3;
  localparam int WIDTH_W   = 24;
  localparam int PERIOD_W  = 24;
  localparam int PINS_W    = 8;

  // Frame period after reset, in ticks.
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd20000;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 2'd0,
    OP_SET_WIDTH = 2'd1,
    OP_STOP      = 2'd2,
    OP_START     = 2'd3
  } op_t;

  // One request as held in the input register.
  typedef struct packed {
    op_t                  operation;
    logic [CHANNEL_W-1:0] channel;
    logic [WIDTH_W-1:0]   width;
  } item_t;

  // One result as loaded into the output register.
  typedef struct packed {
    logic [PINS_W-1:0] pins;
    logic              frame_start;
    logic              running;
  } result_t;

endpackage

// ----- hw/rtl/sequential_slot_pwm_core.sv -----
// ----------------------------------------------------------------------------
// sequential_slot_pwm_core - time-multiplexed multichannel PWM
// Channels take consecutive slots of one frame, followed by a rest slot.
// ----------------------------------------------------------------------------
// The core takes one request per clock while the result side is not stalled
// and returns exactly one result per request, in order, from the result
// register. A request lands in an input register; the
// slot engine then updates the frame and slot state and loads the result
// register in one pass, so a new request is taken every cycle as long as the
// result register is empty or being drained in that same cycle. A tick
// request advances time by one tick: at a frame start the pending widths
// are latched, each channel with a non-zero width drives its one-hot pin for
// that many ticks in channel order, and a rest slot of zeros fills the frame
// up to frame_period ticks (the frame stretches when the widths add up to
// more). Set-width, stop and start requests take no time. A stop request
// takes effect at the next frame start and clears the pins. frame_period is
// written through the configuration channel, which is always ready; write it
// only while no request is in flight, and it applies from the next frame.
// After reset the core is running and the first tick starts a frame.
// ----------------------------------------------------------------------------
module sequential_slot_pwm_core #(
  parameter int NUM_CHANNELS = sspwm_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = sspwm_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [2:0] channel, [26:3] width, upper bits zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] pins, [8] frame_start, [9] running
  // Configuration channel for frame_period.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  sspwm_pkg::item_t   item_r;
  sspwm_pkg::item_t   item_nxt;
  logic               in_valid_r;
  logic               out_valid_r;
  sspwm_pkg::result_t result_r;
  sspwm_pkg::result_t result_nxt;
  logic               advance;

  // The input register moves into the engine whenever the result register
  // is free or is being taken this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign item_nxt.operation = sspwm_pkg::op_t'(in_tuser);
  assign item_nxt.channel   = in_tdata[2:0];
  assign item_nxt.width     = in_tdata[26:3];

  sspwm_engine #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (item_r),
    .cfg_wr     (cfg_valid),
    .cfg_period (cfg_data),
    .result     (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, result_r.running, result_r.frame_start, result_r.pins};

endmodule

// ----- hw/rtl/sspwm_slot_find.sv -----
// ----------------------------------------------------------------------------
// sspwm_slot_find - next occupied channel slot
// Finds the lowest channel at or above a starting slot whose pending or
// latched width, as flagged in the mask, is non-zero.
// ----------------------------------------------------------------------------
module sspwm_slot_find #(
  parameter int NUM_CHANNELS = sspwm_pkg::NUM_CHANNELS_DEF,
  parameter int IDX_W        = 3,
  parameter int SLOT_W       = 4
) (
  input  logic [NUM_CHANNELS-1:0] mask,
  input  logic [SLOT_W:0]         from,
  output logic                    found,
  output logic [IDX_W-1:0]        idx
);

  logic [NUM_CHANNELS-1:0] sel;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      sel[i] = mask[i] && ((SLOT_W+1)'(i) >= from);
    end
  end

  // Scan from the top so the lowest candidate wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (sel[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule

// ----- hw/rtl/sspwm_engine.sv -----
// ----------------------------------------------------------------------------
// sspwm_engine - frame and slot state of the sequential slot PWM
// Holds the pending and active widths, the frame and slot counters and the
// run flags, and works out the result of one request in a single pass.
// ----------------------------------------------------------------------------
module sspwm_engine #(
  parameter int NUM_CHANNELS = sspwm_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = sspwm_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  sspwm_pkg::item_t                  item,
  input  logic                              cfg_wr,
  input  logic [sspwm_pkg::PERIOD_W-1:0]    cfg_period,
  output sspwm_pkg::result_t                result
);

  localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SLOT_W = $clog2(NUM_CHANNELS + 2);
  localparam int SUM_W  = COUNT_BITS + $clog2(NUM_CHANNELS);
  localparam int CHX_W  = IDX_W + sspwm_pkg::CHANNEL_W;
  localparam logic [SLOT_W-1:0] REST_SLOT = SLOT_W'(NUM_CHANNELS);
  localparam logic [SLOT_W-1:0] DONE_SLOT = SLOT_W'(NUM_CHANNELS + 1);

  logic [sspwm_pkg::PERIOD_W-1:0] period_r;
  logic [COUNT_BITS-1:0]          pending_r [NUM_CHANNELS];
  logic [COUNT_BITS-1:0]          pending_nxt [NUM_CHANNELS];
  logic [COUNT_BITS-1:0]          active_r [NUM_CHANNELS];
  logic [COUNT_BITS-1:0]          active_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]        active_nz_r, active_nz_nxt;
  logic [SUM_W-1:0]               sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]          rest_r, rest_nxt;
  logic [SLOT_W-1:0]              slot_r, slot_nxt;
  logic [COUNT_BITS-1:0]          slot_cnt_r, slot_cnt_nxt;
  logic [SUM_W-1:0]               frame_cnt_r, frame_cnt_nxt;
  logic [sspwm_pkg::PINS_W-1:0]   pins_r, pins_nxt;
  logic                           run_r, run_nxt;
  logic                           stop_r, stop_nxt;
  logic                           fstart;

  logic [COUNT_BITS-1:0]          period_eff;
  logic [COUNT_BITS-1:0]          width_cb;
  logic [CHX_W-1:0]               ch_ext;
  logic                           ch_ok;
  logic [IDX_W-1:0]               ch_idx;
  logic [NUM_CHANNELS-1:0]        pend_nz;
  logic [SUM_W-1:0]               period_sum;
  logic                           short_frame;
  logic [SUM_W-1:0]               rest_diff;
  logic [COUNT_BITS-1:0]          rest_new;
  logic [SUM_W-1:0]               frame_new;
  logic                           frame_go;
  logic [NUM_CHANNELS-1:0]        find_mask;
  logic [SLOT_W:0]                find_from;
  logic                           find_hit;
  logic [IDX_W-1:0]               find_idx;
  logic [IDX_W-1:0]               pend_addr;
  logic [COUNT_BITS-1:0]          pend_rd;
  logic [COUNT_BITS-1:0]          act_rd;
  logic [COUNT_BITS-1:0]          rest_sel;
  logic [SLOT_W-1:0]              enter_slot;
  logic [COUNT_BITS-1:0]          enter_cnt;
  logic                           enter_pins_set;
  logic [sspwm_pkg::PINS_W-1:0]   enter_pins;
  logic [IDX_W+1:0]               find_idx_ext;
  logic [COUNT_BITS-1:0]          slot_base;
  logic [SUM_W-1:0]               frame_base;

  // A period of zero counts as one tick.
  assign period_eff = (COUNT_BITS'(period_r) == '0) ? COUNT_BITS'(1) : COUNT_BITS'(period_r);
  assign width_cb   = COUNT_BITS'(item.width);
  assign ch_ext     = CHX_W'(item.channel);
  assign ch_ok      = ch_ext < CHX_W'(NUM_CHANNELS);
  assign ch_idx     = ch_ext[IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      pend_nz[i] = (pending_r[i] != '0);
    end
  end

  // Frame length is the larger of the period and the width sum.
  assign period_sum  = SUM_W'(period_eff);
  assign short_frame = sum_r < period_sum;
  assign rest_diff   = period_sum - sum_r;
  assign rest_new    = short_frame ? rest_diff[COUNT_BITS-1:0] : '0;
  assign frame_new   = short_frame ? period_sum : sum_r;

  assign frame_go = (item.operation == sspwm_pkg::OP_TICK) && run_r &&
                    (frame_cnt_r == '0) && !stop_r;

  assign find_mask = frame_go ? pend_nz : active_nz_r;
  assign find_from = frame_go ? '0 : ((SLOT_W+1)'(slot_r) + (SLOT_W+1)'(1));

  sspwm_slot_find #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IDX_W        (IDX_W),
    .SLOT_W       (SLOT_W)
  ) u_slot_find (
    .mask  (find_mask),
    .from  (find_from),
    .found (find_hit),
    .idx   (find_idx)
  );

  // One read address per width array.
  assign pend_addr = (item.operation == sspwm_pkg::OP_SET_WIDTH) ? ch_idx : find_idx;
  assign pend_rd   = pending_r[pend_addr];
  assign act_rd    = active_r[find_idx];
  assign rest_sel  = frame_go ? rest_new : rest_r;
  assign find_idx_ext = (IDX_W+2)'(find_idx);

  // Slot entry: next occupied channel, else the rest slot, else done.
  always_comb begin
    enter_slot     = DONE_SLOT;
    enter_cnt      = '0;
    enter_pins_set = 1'b0;
    enter_pins     = '0;
    if (find_hit) begin
      enter_slot     = SLOT_W'(find_idx);
      enter_cnt      = frame_go ? pend_rd : act_rd;
      enter_pins_set = 1'b1;
      for (int j = 0; j < sspwm_pkg::PINS_W; j++) begin
        enter_pins[j] = (find_idx_ext == (IDX_W+2)'(j));
      end
    end else if ((find_from <= (SLOT_W+1)'(REST_SLOT)) && (rest_sel != '0)) begin
      enter_slot     = REST_SLOT;
      enter_cnt      = rest_sel;
      enter_pins_set = 1'b1;
    end
  end

  always_comb begin
    pending_nxt   = pending_r;
    active_nxt    = active_r;
    active_nz_nxt = active_nz_r;
    sum_nxt       = sum_r;
    rest_nxt      = rest_r;
    slot_nxt      = slot_r;
    slot_cnt_nxt  = slot_cnt_r;
    frame_cnt_nxt = frame_cnt_r;
    pins_nxt      = pins_r;
    run_nxt       = run_r;
    stop_nxt      = stop_r;
    fstart        = 1'b0;
    slot_base     = slot_cnt_r;
    frame_base    = frame_cnt_r;
    case (item.operation)
      sspwm_pkg::OP_TICK: begin
        if (run_r) begin
          if ((frame_cnt_r == '0) && stop_r) begin
            run_nxt  = 1'b0;
            stop_nxt = 1'b0;
            pins_nxt = '0;
          end else begin
            if (frame_go) begin
              active_nxt    = pending_r;
              active_nz_nxt = pend_nz;
              rest_nxt      = rest_new;
              frame_base    = frame_new;
              fstart        = 1'b1;
            end
            if (frame_go || (slot_cnt_r == '0)) begin
              slot_nxt  = enter_slot;
              slot_base = enter_cnt;
              if (enter_pins_set) begin
                pins_nxt = enter_pins;
              end
            end
            slot_cnt_nxt  = (slot_base != '0) ? slot_base - COUNT_BITS'(1) : slot_base;
            frame_cnt_nxt = (frame_base != '0) ? frame_base - SUM_W'(1) : frame_base;
          end
        end
      end
      sspwm_pkg::OP_SET_WIDTH: begin
        if (ch_ok) begin
          pending_nxt[ch_idx] = width_cb;
          sum_nxt = sum_r - SUM_W'(pend_rd) + SUM_W'(width_cb);
        end
      end
      sspwm_pkg::OP_STOP: begin
        if (run_r) begin
          stop_nxt = 1'b1;
        end
      end
      sspwm_pkg::OP_START: begin
        if (!run_r) begin
          run_nxt       = 1'b1;
          frame_cnt_nxt = '0;
          slot_cnt_nxt  = '0;
          slot_nxt      = '0;
        end
        stop_nxt = 1'b0;
      end
      default: begin
        run_nxt = run_r;
      end
    endcase
  end

  assign result.pins        = pins_nxt;
  assign result.frame_start = fstart;
  assign result.running     = run_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= sspwm_pkg::PERIOD_RESET;
    end else if (cfg_wr) begin
      period_r <= cfg_period;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pending_r[i] <= '0;
        active_r[i]  <= '0;
      end
      active_nz_r <= '0;
      sum_r       <= '0;
      rest_r      <= '0;
      slot_r      <= '0;
      slot_cnt_r  <= '0;
      frame_cnt_r <= '0;
      pins_r      <= '0;
      run_r       <= 1'b1;
      stop_r      <= 1'b0;
    end else if (step) begin
      pending_r   <= pending_nxt;
      active_r    <= active_nxt;
      active_nz_r <= active_nz_nxt;
      sum_r       <= sum_nxt;
      rest_r      <= rest_nxt;
      slot_r      <= slot_nxt;
      slot_cnt_r  <= slot_cnt_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      pins_r      <= pins_nxt;
      run_r       <= run_nxt;
      stop_r      <= stop_nxt;
    end
  end

endmodule
